// ===== hdl/eus_pkg.sv =====
`default_nettype none

package eus_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxRes  = 5;
  localparam int unsigned CntW    = $clog2(MaxRes + 1);
  localparam int unsigned HeldMax = 4;

  localparam logic [ByteW-1:0] ChAmp    = 8'h26;
  localparam logic [ByteW-1:0] ChHash   = 8'h23;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;
  localparam logic [ByteW-1:0] ChOne    = 8'h31;
  localparam logic [ByteW-1:0] ChThree  = 8'h33;
  localparam logic [ByteW-1:0] ChFour   = 8'h34;
  localparam logic [ByteW-1:0] ChSemi   = 8'h3B;
  localparam logic [ByteW-1:0] ChLowA   = 8'h61;
  localparam logic [ByteW-1:0] ChLowM   = 8'h6D;
  localparam logic [ByteW-1:0] ChLowP   = 8'h70;
  localparam logic [ByteW-1:0] ChLBrack = 8'h5B;
  localparam logic [ByteW-1:0] ChRBrack = 8'h5D;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;

  typedef enum logic [3:0] {
    P_IDLE    = 4'd0,
    P_AMP     = 4'd1,
    P_HASH    = 4'd2,
    P_H9      = 4'd3,
    P_H91     = 4'd4,
    P_H93     = 4'd5,
    P_H4      = 4'd6,
    P_H44     = 4'd7,
    P_A       = 4'd8,
    P_AM      = 4'd9,
    P_AMP_END = 4'd10
  } prefix_e;

  typedef enum logic [1:0] {
    ADV_MORE,
    ADV_DONE,
    ADV_FAIL
  } adv_kind_e;

  typedef struct packed {
    adv_kind_e        kind;
    prefix_e          nxt;
    logic [ByteW-1:0] dec;
  } adv_t;

  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              count;
    prefix_e                      nxt;
  } dec_res_t;

  function automatic adv_t advance(prefix_e st, logic [ByteW-1:0] c);
    adv_t r;
    r.kind = ADV_FAIL;
    r.nxt  = P_IDLE;
    r.dec  = '0;
    case (st)
      P_AMP: begin
        if (c == ChHash) begin
          r.kind = ADV_MORE; r.nxt = P_HASH;
        end else if (c == ChLowA) begin
          r.kind = ADV_MORE; r.nxt = P_A;
        end
      end
      P_HASH: begin
        if (c == ChNine) begin
          r.kind = ADV_MORE; r.nxt = P_H9;
        end else if (c == ChFour) begin
          r.kind = ADV_MORE; r.nxt = P_H4;
        end
      end
      P_H9: begin
        if (c == ChOne) begin
          r.kind = ADV_MORE; r.nxt = P_H91;
        end else if (c == ChThree) begin
          r.kind = ADV_MORE; r.nxt = P_H93;
        end
      end
      P_H91: begin
        if (c == ChSemi) begin
          r.kind = ADV_DONE; r.dec = ChLBrack;
        end
      end
      P_H93: begin
        if (c == ChSemi) begin
          r.kind = ADV_DONE; r.dec = ChRBrack;
        end
      end
      P_H4: begin
        if (c == ChFour) begin
          r.kind = ADV_MORE; r.nxt = P_H44;
        end
      end
      P_H44: begin
        if (c == ChSemi) begin
          r.kind = ADV_DONE; r.dec = ChComma;
        end
      end
      P_A: begin
        if (c == ChLowM) begin
          r.kind = ADV_MORE; r.nxt = P_AM;
        end
      end
      P_AM: begin
        if (c == ChLowP) begin
          r.kind = ADV_MORE; r.nxt = P_AMP_END;
        end
      end
      P_AMP_END: begin
        if (c == ChSemi) begin
          r.kind = ADV_DONE; r.dec = ChAmp;
        end
      end
      default: begin
        r.kind = ADV_FAIL;
      end
    endcase
    return r;
  endfunction

  function automatic logic [HeldMax-1:0][ByteW-1:0] held_text(prefix_e st);
    logic [HeldMax-1:0][ByteW-1:0] t;
    t = '0;
    case (st)
      P_AMP:     t[0] = ChAmp;
      P_HASH:    begin t[0] = ChAmp; t[1] = ChHash; end
      P_H9:      begin t[0] = ChAmp; t[1] = ChHash; t[2] = ChNine; end
      P_H91:     begin t[0] = ChAmp; t[1] = ChHash; t[2] = ChNine; t[3] = ChOne; end
      P_H93:     begin t[0] = ChAmp; t[1] = ChHash; t[2] = ChNine; t[3] = ChThree; end
      P_H4:      begin t[0] = ChAmp; t[1] = ChHash; t[2] = ChFour; end
      P_H44:     begin t[0] = ChAmp; t[1] = ChHash; t[2] = ChFour; t[3] = ChFour; end
      P_A:       begin t[0] = ChAmp; t[1] = ChLowA; end
      P_AM:      begin t[0] = ChAmp; t[1] = ChLowA; t[2] = ChLowM; end
      P_AMP_END: begin t[0] = ChAmp; t[1] = ChLowA; t[2] = ChLowM; t[3] = ChLowP; end
      default:   t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [CntW-1:0] held_len(prefix_e st);
    logic [CntW-1:0] n;
    case (st)
      P_AMP:                      n = CntW'(1);
      P_HASH, P_A:                n = CntW'(2);
      P_H9, P_H4, P_AM:           n = CntW'(3);
      P_H91, P_H93, P_H44,
      P_AMP_END:                  n = CntW'(4);
      default:                    n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/eus_decode.sv =====
`default_nettype none

module eus_decode import eus_pkg::*; (
  input  prefix_e          state_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output dec_res_t         res_o
);

  adv_t                          adv;
  logic [HeldMax-1:0][ByteW-1:0] held_a;
  logic [HeldMax-1:0][ByteW-1:0] held_b;
  logic [CntW-1:0]               len_a;
  logic [CntW-1:0]               len_b;
  logic [CntW-1:0]               idx;
  logic [MaxRes-1:0][ByteW-1:0]  lst;
  logic [CntW-1:0]               n;
  prefix_e                       ns;

  always_comb begin
    adv    = advance(state_i, byte_i);
    held_a = held_text(state_i);
    len_a  = held_len(state_i);
    lst    = '0;
    n      = '0;
    ns     = state_i;
    idx    = '0;

    case (adv.kind)
      ADV_DONE: begin
        lst[0] = adv.dec;
        n      = CntW'(1);
        ns     = P_IDLE;
      end
      ADV_FAIL: begin
        for (int i = 0; i < HeldMax; i++) begin
          if (CntW'(i) < len_a) begin
            lst[i] = held_a[i];
          end
        end
        n = len_a;
        if (byte_i == ChAmp) begin
          ns = P_AMP;
        end else begin
          lst[len_a] = byte_i;
          n          = len_a + CntW'(1);
          ns         = P_IDLE;
        end
      end
      default: begin
        ns = adv.nxt;
      end
    endcase

    held_b = held_text(ns);
    len_b  = held_len(ns);
    if (last_i) begin
      for (int i = 0; i < HeldMax; i++) begin
        idx = n + CntW'(i);
        if ((CntW'(i) < len_b) && (idx < CntW'(MaxRes))) begin
          lst[idx] = held_b[i];
        end
      end
      n  = n + len_b;
      ns = P_IDLE;
    end

    res_o.bytes = lst;
    res_o.count = n;
    res_o.nxt   = ns;
  end

endmodule

`default_nettype wire

// ===== hdl/entity_unescape_stream_unit.sv =====
// Channel   Direction  tdata       tuser      tlast
// s_axis    in         in_byte     -          message_end
// m_axis    out        out_byte    run_last   message_done
//
// An input transaction is decoded in the cycle it is accepted and its results
// are loaded into a five-byte output queue that drains one byte a cycle while
// the output is ready. An item with no result, or one taken at once, leaves the
// input ready in the next cycle, so unstalled plain text streams at one byte per
// cycle. A broken or flushed prefix gives up to five results and holds the input
// until its last is taken. Reset clears the prefix state and queue count. A
// stalled output holds its byte and keeps the input stalled until it leaves.
`default_nettype none

module entity_unescape_stream_unit import eus_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [ByteW-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tuser,   // [0] run_last
  output logic             m_axis_tlast
);

  prefix_e                      state_q;
  logic [CntW-1:0]              rem_q;
  logic                         done_q;
  logic [MaxRes-1:0][ByteW-1:0] obuf_q;
  dec_res_t                     res;
  logic                         in_acc;
  logic                         out_acc;

  eus_decode u_decode (
    .state_i (state_q),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .res_o   (res)
  );

  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tdata  = obuf_q[0];
  assign m_axis_tuser  = (rem_q == CntW'(1));
  assign m_axis_tlast  = (rem_q == CntW'(1)) && done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      rem_q   <= '0;
      done_q  <= 1'b0;
    end else if (in_acc) begin
      state_q <= res.nxt;
      rem_q   <= res.count;
      done_q  <= s_axis_tlast;
    end else if (out_acc) begin
      rem_q   <= rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      obuf_q <= res.bytes;
    end else if (out_acc) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        obuf_q[i] <= obuf_q[i+1];
      end
      obuf_q[MaxRes-1] <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eus_checker.sv =====
`default_nettype none

module eus_checker import eus_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             s_axis_tlast,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [ByteW-1:0] m_axis_tdata,
  input wire logic             m_axis_tuser,
  input wire logic             m_axis_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction withdrawn while stalled");

  // A stalled result keeps its contents.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
    else $error("output transaction changed while stalled");

  // The end of a message is always the last result of its input byte.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("message end not on the last result of a run");

  // The last byte of a message always produces at least one result.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("message end produced no result");

  // The input only waits behind pending results.
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind entity_unescape_stream_unit eus_checker u_eus_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
